// File: sv/touch_sample_average_scale_top_macros.svh
// Assertion macros shared by the touch averaging checker.
// No dependencies; include by bare file name.
`ifndef TOUCH_SAMPLE_AVERAGE_SCALE_TOP_MACROS_SVH
`define TOUCH_SAMPLE_AVERAGE_SCALE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define TSAS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("touch average check failed (same cycle)");

// Next-cycle implication, checked on every rising edge out of reset.
`define TSAS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("touch average check failed (next cycle)");

`endif

// File: sv/tsas_pkg.sv
// Shared constants, types and helpers for the touch sample averaging block.
// No dependencies; imported by the lane and top-level RTL modules of the block.
package tsas_pkg;

  localparam int SAMPLE_BITS = 13;
  localparam int SUM_W       = 21;
  localparam int CNT_W       = 8;
  localparam int PIX_W       = 12;
  localparam int BYTE_W      = 8;
  localparam int DIV_DW      = SAMPLE_BITS + PIX_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CNT_W-1:0]       AVG_COUNT_RST = CNT_W'(64);
  localparam logic [SAMPLE_BITS-1:0] LIMIT_HI_RST  = '1;
  localparam logic [SAMPLE_BITS-1:0] LIMIT_LO_RST  = '0;
  localparam logic [PIX_W-1:0]       WIDTH_RST     = PIX_W'(320);
  localparam logic [PIX_W-1:0]       HEIGHT_RST    = PIX_W'(240);

  localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd6;

  typedef struct packed {
    logic add;
    logic start;
    logic ack;
  } lane_ctl_t;

  typedef struct packed {
    logic done;
  } lane_sts_t;

  // The converter returns the value left aligned over two bytes.
  function automatic logic [SAMPLE_BITS-1:0] raw_of(input logic [BYTE_W-1:0] hi,
                                                    input logic [BYTE_W-1:0] lo);
    return SAMPLE_BITS'({hi, lo[BYTE_W-1:3]});
  endfunction

endpackage

// File: sv/tsas_div.sv
// Restoring divider, one quotient bit per cycle, for the axis lanes.
// Depends on nothing but its parameters.
module tsas_div #(
  parameter int DW = 25,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW:0]   rem_sh;
  logic          ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DW-1]};
    ge       = rem_sh >= {1'b0, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DW-2:0], ge};
      rem_nxt = ge ? VW'(rem_sh - {1'b0, dsr_r}) : rem_sh[VW-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/tsas_lane.sv
// One axis lane: sums raw samples, divides by the count, clamps and scales.
// Depends on tsas_pkg and tsas_div.
module tsas_lane
  import tsas_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  lane_ctl_t              ctl,
  output lane_sts_t              sts,
  input  logic [SAMPLE_BITS-1:0] raw,
  input  logic [CNT_W-1:0]       count,
  input  logic [SAMPLE_BITS-1:0] lim_hi,
  input  logic [SAMPLE_BITS-1:0] lim_lo,
  input  logic [PIX_W-1:0]       range_px,
  output logic [PIX_W-1:0]       scaled
);

  typedef enum logic [5:0] {
    L_IDLE  = 6'b000001,
    L_AVG   = 6'b000010,
    L_MUL   = 6'b000100,
    L_LOAD  = 6'b001000,
    L_SCALE = 6'b010000,
    L_HOLD  = 6'b100000
  } lane_state_t;

  lane_state_t            state_r, state_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] diff_r, diff_nxt;
  logic [SAMPLE_BITS-1:0] den_r, den_nxt;
  logic                   zero_r, zero_nxt;
  logic [DIV_DW-1:0]      prod_r, prod_nxt;
  logic [PIX_W-1:0]       res_r, res_nxt;
  logic                   div_start;
  logic [DIV_DW-1:0]      div_dvd;
  logic [SAMPLE_BITS-1:0] div_dsr;
  logic                   div_done;
  logic [DIV_DW-1:0]      div_quo;
  logic [SAMPLE_BITS-1:0] clamped;

  tsas_div #(
    .DW (DIV_DW),
    .VW (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Clamp the average to the high limit first, then to the low limit.
  always_comb begin
    clamped = (div_quo > DIV_DW'(lim_hi)) ? lim_hi : div_quo[SAMPLE_BITS-1:0];
    if (clamped < lim_lo) begin
      clamped = lim_lo;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    diff_nxt  = diff_r;
    den_nxt   = den_r;
    zero_nxt  = zero_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    div_start = 1'b0;
    div_dvd   = DIV_DW'(sum_r);
    div_dsr   = SAMPLE_BITS'(count);
    if (ctl.add) begin
      sum_nxt = sum_r + SUM_W'(raw);
    end
    case (state_r)
      L_IDLE: begin
        if (ctl.start) begin
          div_start = 1'b1;
          sum_nxt   = '0;
          state_nxt = L_AVG;
        end
      end
      L_AVG: begin
        if (div_done) begin
          diff_nxt  = clamped - lim_lo;
          den_nxt   = lim_hi - lim_lo;
          zero_nxt  = lim_hi <= lim_lo;
          state_nxt = L_MUL;
        end
      end
      L_MUL: begin
        prod_nxt  = DIV_DW'(diff_r) * DIV_DW'(range_px);
        state_nxt = L_LOAD;
      end
      L_LOAD: begin
        div_start = 1'b1;
        div_dvd   = prod_r;
        div_dsr   = den_r;
        state_nxt = L_SCALE;
      end
      L_SCALE: begin
        if (div_done) begin
          res_nxt   = zero_r ? '0 : div_quo[PIX_W-1:0];
          state_nxt = L_HOLD;
        end
      end
      L_HOLD: begin
        if (ctl.ack) begin
          state_nxt = L_IDLE;
        end
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= diff_nxt;
    den_r  <= den_nxt;
    zero_r <= zero_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
  end

  assign sts.done = (state_r == L_HOLD);
  assign scaled   = res_r;

endmodule

// File: sv/touch_sample_average_scale_top.sv
// Touch sample averaging and calibration: takes one X/Y converter byte set per
// request, sums the raw values and, once avg_count samples (at least one) are in, reports one
// clamped and scaled screen coordinate pair with Y flipped against the height.
// A sample that does not complete a run leaves the input ready. The sample that
// completes a run holds the input off until the pair is reported: each axis lane runs two
// 25-step restoring divides in turn (sum by count, then the scaled product by
// the calibration span), and the X and Y lanes work side by side.
// Depends on tsas_pkg, tsas_lane and tsas_div.
module touch_sample_average_scale_top
  import tsas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [7:0] x_high_byte, [15:8] x_low_byte, [23:16] y_high_byte, [31:24] y_low_byte
  input  logic [4*BYTE_W-1:0]   in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [11:0] x_pixel, [23:12] y_pixel
  output logic [2*PIX_W-1:0]    out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    T_IDLE  = 3'b001,
    T_START = 3'b010,
    T_RUN   = 3'b100
  } top_state_t;

  top_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       taken_r, taken_nxt;
  logic [CNT_W-1:0]       avg_count_r;
  logic [SAMPLE_BITS-1:0] x_hi_r, x_lo_r, y_hi_r, y_lo_r;
  logic [PIX_W-1:0]       width_r, height_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]       out_x_r, out_x_nxt;
  logic [PIX_W-1:0]       out_y_r, out_y_nxt;
  logic [CNT_W-1:0]       need;
  logic [CNT_W-1:0]       taken_inc;
  logic                   in_acc;
  logic                   out_free;
  logic                   report;
  lane_ctl_t              ctl;
  lane_sts_t              x_sts, y_sts;
  logic [PIX_W-1:0]       x_scaled, y_scaled;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == T_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign report    = (state_r == T_RUN) && x_sts.done && y_sts.done && out_free;
  assign need      = (avg_count_r == '0) ? CNT_W'(1) : avg_count_r;
  assign taken_inc = taken_r + CNT_W'(1);

  assign ctl.add   = in_acc;
  assign ctl.start = (state_r == T_START);
  assign ctl.ack   = report;

  tsas_lane u_lane_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sts      (x_sts),
    .raw      (raw_of(in_tdata[BYTE_W-1:0], in_tdata[2*BYTE_W-1:BYTE_W])),
    .count    (taken_r),
    .lim_hi   (x_hi_r),
    .lim_lo   (x_lo_r),
    .range_px (width_r),
    .scaled   (x_scaled)
  );

  tsas_lane u_lane_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .sts      (y_sts),
    .raw      (raw_of(in_tdata[3*BYTE_W-1:2*BYTE_W], in_tdata[4*BYTE_W-1:3*BYTE_W])),
    .count    (taken_r),
    .lim_hi   (y_hi_r),
    .lim_lo   (y_lo_r),
    .range_px (height_r),
    .scaled   (y_scaled)
  );

  always_comb begin
    state_nxt     = state_r;
    taken_nxt     = taken_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          taken_nxt = taken_inc;
          if (taken_inc >= need) begin
            state_nxt = T_START;
          end
        end
      end
      T_START: begin
        // The lanes latch the count as divisor on this cycle.
        taken_nxt = '0;
        state_nxt = T_RUN;
      end
      T_RUN: begin
        if (report) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = x_scaled;
          out_y_nxt     = height_r - y_scaled;
          state_nxt     = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      taken_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      taken_r     <= taken_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_count_r <= AVG_COUNT_RST;
      x_hi_r      <= LIMIT_HI_RST;
      x_lo_r      <= LIMIT_LO_RST;
      y_hi_r      <= LIMIT_HI_RST;
      y_lo_r      <= LIMIT_LO_RST;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AVG_COUNT:  avg_count_r <= cfg_data[CNT_W-1:0];
        REG_X_LIMIT_HI: x_hi_r      <= cfg_data[SAMPLE_BITS-1:0];
        REG_X_LIMIT_LO: x_lo_r      <= cfg_data[SAMPLE_BITS-1:0];
        REG_Y_LIMIT_HI: y_hi_r      <= cfg_data[SAMPLE_BITS-1:0];
        REG_Y_LIMIT_LO: y_lo_r      <= cfg_data[SAMPLE_BITS-1:0];
        REG_WIDTH:      width_r     <= cfg_data[PIX_W-1:0];
        REG_HEIGHT:     height_r    <= cfg_data[PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};

endmodule

// File: sv/tsas_checker.sv
// Port-level checker for the touch averaging block, bound to the top level.
// Depends on tsas_pkg and touch_sample_average_scale_top_macros.svh.
`include "touch_sample_average_scale_top_macros.svh"

module tsas_checker
  import tsas_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [2*PIX_W-1:0] out_tdata
);

  // A waiting result keeps its value until the request completes.
  `TSAS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // A new result only appears as the block leaves its busy phase.
  `TSAS_ASSERT_IMPL(a_rose_from_busy, clk, rst_n, $rose(out_tvalid), in_tready && !$past(in_tready))

  // Back-to-back results need a busy phase in between.
  `TSAS_ASSERT_NEXT(a_next_from_busy, clk, rst_n, out_tvalid && out_tready, !out_tvalid || !$past(in_tready))

  // A request taken on the input never coincides with a result being loaded.
  `TSAS_ASSERT_IMPL(a_no_input_at_load, clk, rst_n, in_tvalid && in_tready, !$fell(in_tready))

endmodule

bind touch_sample_average_scale_top tsas_checker u_tsas_checker (.*);

// File: sim/touch_coord_checker.sv
`timescale 1ns / 1ps
// Checker for the touch sample averaging block: mirrors its registers and running
// sums, predicts each coordinate pair and compares it with the result channel.
// Depends on tsas_pkg.
module touch_coord_checker
  import tsas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [4*BYTE_W-1:0]   in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [2*PIX_W-1:0]    out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    pair_count
);

  // Same layout as out_tdata: x_pixel in the low bits.
  typedef struct packed {
    logic [PIX_W-1:0] y_pixel;
    logic [PIX_W-1:0] x_pixel;
  } coord_t;

  coord_t coord_q[$];

  logic [CNT_W-1:0]       avg_count_r;
  logic [SAMPLE_BITS-1:0] x_hi_r, x_lo_r, y_hi_r, y_lo_r;
  logic [PIX_W-1:0]       width_r, height_r;
  logic [SUM_W-1:0]       x_acc, y_acc;
  logic [CNT_W-1:0]       taken;
  int                     fails = 0;
  int                     pairs = 0;

  // Clamp an averaged raw value into its calibration window and map it onto
  // span_px screen steps, truncating. An empty or reversed window maps to zero.
  function automatic logic [PIX_W-1:0] to_screen(input logic [SAMPLE_BITS-1:0] avg, hi, lo,
                                                 input logic [PIX_W-1:0] span_px);
    logic [SAMPLE_BITS-1:0] v;
    logic [DIV_DW-1:0]      prod;
    if (hi <= lo) return '0;
    v = (avg > hi) ? hi : avg;
    if (v < lo) v = lo;
    prod = (v - lo) * span_px;
    return PIX_W'(prod / DIV_DW'(hi - lo));
  endfunction

  always @(posedge clk) begin : watch
    coord_t                 got, want;
    logic [CNT_W-1:0]       need;
    logic [SAMPLE_BITS-1:0] x_avg, y_avg;
    if (!rst_n) begin
      avg_count_r = AVG_COUNT_RST;
      x_hi_r      = LIMIT_HI_RST;
      x_lo_r      = LIMIT_LO_RST;
      y_hi_r      = LIMIT_HI_RST;
      y_lo_r      = LIMIT_LO_RST;
      width_r     = WIDTH_RST;
      height_r    = HEIGHT_RST;
      x_acc       = '0;
      y_acc       = '0;
      taken       = '0;
      coord_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_AVG_COUNT:  avg_count_r = cfg_data[CNT_W-1:0];
          REG_X_LIMIT_HI: x_hi_r      = cfg_data[SAMPLE_BITS-1:0];
          REG_X_LIMIT_LO: x_lo_r      = cfg_data[SAMPLE_BITS-1:0];
          REG_Y_LIMIT_HI: y_hi_r      = cfg_data[SAMPLE_BITS-1:0];
          REG_Y_LIMIT_LO: y_lo_r      = cfg_data[SAMPLE_BITS-1:0];
          REG_WIDTH:      width_r     = cfg_data[PIX_W-1:0];
          REG_HEIGHT:     height_r    = cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end

      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (coord_q.size() == 0) begin
          fails++;
          $display("%0t: unrequested coordinate pair, expected none, got x=%0d y=%0d",
                   $time, got.x_pixel, got.y_pixel);
        end else begin
          want = coord_q.pop_front();
          pairs++;
          if (got.x_pixel !== want.x_pixel) begin
            fails++;
            $display("%0t: x_pixel mismatch, expected %0d, got %0d",
                     $time, want.x_pixel, got.x_pixel);
          end
          if (got.y_pixel !== want.y_pixel) begin
            fails++;
            $display("%0t: y_pixel mismatch, expected %0d, got %0d",
                     $time, want.y_pixel, got.y_pixel);
          end
        end
      end

      if (in_tvalid && in_tready) begin
        // Raw value is the high byte followed by the top five bits of the low byte.
        x_acc = x_acc + {in_tdata[7:0], in_tdata[15:11]};
        y_acc = y_acc + {in_tdata[23:16], in_tdata[31:27]};
        taken = taken + 1'b1;
        need  = (avg_count_r == '0) ? CNT_W'(1) : avg_count_r;
        // A count lowered below what is already summed reports at once, divided
        // by the number of samples actually taken.
        if (taken >= need) begin
          x_avg        = SAMPLE_BITS'(x_acc / taken);
          y_avg        = SAMPLE_BITS'(y_acc / taken);
          want.x_pixel = to_screen(x_avg, x_hi_r, x_lo_r, width_r);
          want.y_pixel = height_r - to_screen(y_avg, y_hi_r, y_lo_r, height_r);
          coord_q.push_back(want);
          x_acc = '0;
          y_acc = '0;
          taken = '0;
        end
      end
    end
    fail_count <= fails;
    pair_count <= pairs;
    pending    <= coord_q.size();
  end

endmodule

// File: sim/tb_touch_sample_average_scale_top.sv
`timescale 1ns / 1ps
// Testbench top for the touch sample averaging block: drives samples and register
// writes with random gaps and stalls. Depends on tsas_pkg, the block and touch_coord_checker.
module tb_touch_sample_average_scale_top;
  import tsas_pkg::*;

  // The index above the last register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [4*BYTE_W-1:0]   in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tready, out_tvalid, cfg_ready;
  logic [2*PIX_W-1:0]    out_tdata;
  int                    fail_count, pending, pair_count;

  bit                    no_gaps        = 1'b0;
  int                    ready_hold     = 0;
  int                    sent           = 0;
  int                    settings_used  = 0;
  logic [CFG_DATA_W-1:0] setting [8];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  touch_sample_average_scale_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  touch_coord_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .pair_count (pair_count)
  );

  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixels();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PIX_W'($urandom_range(1, 4094));
  endfunction

  // Full range, reversed or empty, or an ordinary window.
  task automatic pick_window(output logic [SAMPLE_BITS-1:0] lo, hi);
    int r, l;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      lo = '0;
      hi = '1;
    end else if (r == 1) begin
      hi = SAMPLE_BITS'($urandom);
      lo = SAMPLE_BITS'($urandom_range(int'(hi), 8191));
    end else begin
      l  = $urandom_range(0, 6000);
      lo = SAMPLE_BITS'(l);
      hi = SAMPLE_BITS'($urandom_range(l + 1, 8191));
    end
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold <= pick_gap();
    end
  end

  // Entered at a clock edge; tvalid stays high after acceptance so that the next
  // request can follow without a bubble.
  task automatic send_sample(input logic [BYTE_W-1:0] xh, xl, yh, yl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {yl, yh, xl, xh};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Splits raw values into converter bytes; the three unused low bits are random.
  task automatic send_raw(input logic [SAMPLE_BITS-1:0] xr, yr);
    send_sample(xr[12:5], {xr[4:0], 3'($urandom)}, yr[12:5], {yr[4:0], 3'($urandom)});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input logic [6:0] mask);
    for (int i = REG_AVG_COUNT; i <= REG_HEIGHT; i++) begin
      if (mask[CFG_IDX_W'(i)]) write_reg(CFG_IDX_W'(i), setting[CFG_IDX_W'(i)]);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Waits until every predicted pair has been received, then keeps the input idle before the next register write.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  initial begin : stimulus
    int                     n_items, spread;
    logic [SAMPLE_BITS-1:0] cx, cy, lo, hi;
    logic [CNT_W-1:0]       avg8;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A zero count reports every sample; full-range limits and largest screen.
    setting[REG_AVG_COUNT]  = '0;
    setting[REG_X_LIMIT_HI] = LIMIT_HI_RST;
    setting[REG_X_LIMIT_LO] = LIMIT_LO_RST;
    setting[REG_Y_LIMIT_HI] = LIMIT_HI_RST;
    setting[REG_Y_LIMIT_LO] = LIMIT_LO_RST;
    setting[REG_WIDTH]      = 13'd4095;
    setting[REG_HEIGHT]     = 13'd4095;
    apply_setting(7'h7F);
    send_sample(8'h00, 8'h00, 8'h00, 8'h00);
    send_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_sample(8'hAA, 8'h55, 8'h55, 8'hAA);
    send_sample(8'h00, 8'h07, 8'h80, 8'hF8);
    drain();

    // Narrow windows and zero width: below, inside and above the window.
    setting[REG_AVG_COUNT]  = 13'd1;
    setting[REG_X_LIMIT_HI] = 13'd2000;
    setting[REG_X_LIMIT_LO] = 13'd1000;
    setting[REG_Y_LIMIT_HI] = 13'd3001;
    setting[REG_Y_LIMIT_LO] = 13'd3000;
    setting[REG_WIDTH]      = '0;
    apply_setting(7'h7F);
    send_raw(13'd500, 13'd2000);
    send_raw(13'd1500, 13'd3001);
    send_raw(13'd8191, 13'd8191);
    drain();

    // Equal limits on X, reversed limits on Y; a write past the last register.
    setting[REG_X_LIMIT_HI] = 13'd500;
    setting[REG_X_LIMIT_LO] = 13'd500;
    setting[REG_Y_LIMIT_HI] = 13'd100;
    setting[REG_Y_LIMIT_LO] = 13'd7000;
    setting[REG_WIDTH]      = 13'd320;
    write_reg(REG_UNUSED, '1);
    apply_setting(7'h7F);
    send_raw(13'd500, 13'd50);
    send_raw(13'd8000, 13'd8000);
    drain();

    // Count lowered while samples are already summed.
    setting[REG_AVG_COUNT]  = 13'd8;
    setting[REG_X_LIMIT_HI] = LIMIT_HI_RST;
    setting[REG_X_LIMIT_LO] = LIMIT_LO_RST;
    setting[REG_Y_LIMIT_HI] = LIMIT_HI_RST;
    setting[REG_Y_LIMIT_LO] = LIMIT_LO_RST;
    setting[REG_WIDTH]      = WIDTH_RST;
    setting[REG_HEIGHT]     = HEIGHT_RST;
    apply_setting(7'h7F);
    repeat (5) send_raw(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    drain();
    setting[REG_AVG_COUNT] = 13'd3;
    apply_setting(7'h01);
    send_raw(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom));
    drain();

    for (int p = 0; p < 20; p++) begin
      no_gaps = (p % 5 == 2);
      case ($urandom_range(0, 9))
        0:       avg8 = '0;
        1:       avg8 = CNT_W'($urandom_range(9, 255));
        default: avg8 = CNT_W'($urandom_range(1, 6));
      endcase
      if (p == 1) avg8 = '0;
      if (p == 6) avg8 = '1;
      n_items = (p == 6) ? 300 : $urandom_range(20, 60);
      // Unused upper bits of the narrower registers carry junk on purpose.
      setting[REG_AVG_COUNT] = {5'($urandom), avg8};
      pick_window(lo, hi);
      setting[REG_X_LIMIT_LO] = lo;
      setting[REG_X_LIMIT_HI] = hi;
      pick_window(lo, hi);
      setting[REG_Y_LIMIT_LO] = lo;
      setting[REG_Y_LIMIT_HI] = hi;
      setting[REG_WIDTH]      = {1'($urandom), pick_pixels()};
      setting[REG_HEIGHT]     = {1'($urandom), pick_pixels()};
      apply_setting((p == 0) ? 7'h7F : (7'($urandom) | ((p == 1 || p == 6) ? 7'h01 : 7'h00)));

      // Most samples scatter around a touch point inside the window; the rest
      // are arbitrary converter bytes.
      cx     = SAMPLE_BITS'($urandom_range(setting[REG_X_LIMIT_LO], setting[REG_X_LIMIT_HI]));
      cy     = SAMPLE_BITS'($urandom_range(setting[REG_Y_LIMIT_LO], setting[REG_Y_LIMIT_HI]));
      spread = $urandom_range(0, 63);
      repeat (n_items) begin
        if ($urandom_range(0, 9) < 7)
          send_raw(cx + SAMPLE_BITS'($urandom_range(0, spread)) - SAMPLE_BITS'(spread / 2),
                   cy + SAMPLE_BITS'($urandom_range(0, spread)) - SAMPLE_BITS'(spread / 2));
        else
          send_sample(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                      BYTE_W'($urandom));
      end
      drain();
    end

    $display("Sent %0d touch samples under %0d register settings.", sent, settings_used);
    $display("Checked %0d coordinate pairs across clamped, unordered and zero-count cases.",
             pair_count);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Ends the run with a failure message if the stimulus hangs; the limit is meant to cover the worst
  // correct run (every sample completing a pair, longest gaps and stalls).
  initial begin : watchdog
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
